// ===== rtl/sph_pkg.sv =====
// severity priority heap: shared types, constants and the microcode table
// no dependencies; imported by every module of the block except sph_ram
`default_nettype none

package sph_pkg;

    localparam int CAPACITY = 128;
    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int LW = AW + 2;

    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 64;

    typedef struct packed {
        logic [15:0] tag;
        logic [31:0] ts;
        logic [7:0]  sev;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef enum logic [1:0] {
        ST_ADDED      = 2'd0,
        ST_DISPATCHED = 2'd1,
        ST_EMPTY      = 2'd2,
        ST_FULL       = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_START,
        C_DISP,
        C_FULL,
        C_POS_ZERO,
        C_NOT_UP,
        C_EMPTY,
        C_NO_LEFT,
        C_NO_RIGHT,
        C_BEST_IS_POS,
        C_OUT_FREE
    } cond_t;

    typedef enum logic [2:0] {
        RD_PARENT,
        RD_ROOT,
        RD_LAST,
        RD_LEFT,
        RD_RIGHT
    } rd_sel_t;

    typedef enum logic [1:0] {
        WR_RD,
        WR_CUR,
        WR_BEST
    } wr_sel_t;

    typedef enum logic [2:0] {
        POS_KEEP,
        POS_COUNT,
        POS_ZERO,
        POS_PARENT,
        POS_BEST
    } pos_op_t;

    typedef enum logic [1:0] {
        CUR_KEEP,
        CUR_IN,
        CUR_RD
    } cur_op_t;

    typedef enum logic [1:0] {
        BEST_KEEP,
        BEST_LEFT,
        BEST_RIGHT
    } best_op_t;

    typedef enum logic [1:0] {
        CNT_KEEP,
        CNT_INC,
        CNT_DEC
    } cnt_op_t;

    typedef logic [4:0] step_t;

    localparam step_t U_IDLE    = 5'd0;
    localparam step_t U_DECODE  = 5'd1;
    localparam step_t U_ADD     = 5'd2;
    localparam step_t U_UPTEST  = 5'd3;
    localparam step_t U_UPCMP   = 5'd4;
    localparam step_t U_UPMOVE  = 5'd5;
    localparam step_t U_UPPLACE = 5'd6;
    localparam step_t U_EADD    = 5'd7;
    localparam step_t U_EFULL   = 5'd8;
    localparam step_t U_EEMPTY  = 5'd9;
    localparam step_t U_D0      = 5'd10;
    localparam step_t U_D1      = 5'd11;
    localparam step_t U_D2      = 5'd12;
    localparam step_t U_D3      = 5'd13;
    localparam step_t U_DNTEST  = 5'd14;
    localparam step_t U_DNL     = 5'd15;
    localparam step_t U_DNR     = 5'd16;
    localparam step_t U_DNCHK   = 5'd17;
    localparam step_t U_DNMOVE  = 5'd18;
    localparam step_t U_DNPLACE = 5'd19;
    localparam step_t U_EDISP   = 5'd20;

    typedef struct packed {
        cond_t    cond;
        step_t    target;
        logic     hold;
        logic     take;
        logic     rd_en;
        rd_sel_t  rd_sel;
        logic     wr_en;
        wr_sel_t  wr_sel;
        pos_op_t  pos_op;
        cur_op_t  cur_op;
        best_op_t best_op;
        cnt_op_t  cnt_op;
        logic     out_load;
        logic     emit;
        status_t  emit_status;
        logic     emit_zero;
    } ctrl_t;

    typedef struct packed {
        logic full;
        logic empty;
        logic pos_zero;
        logic not_up;
        logic no_left;
        logic no_right;
        logic best_is_pos;
    } dp_flags_t;

    typedef struct packed {
        logic      start;
        logic      disp;
        logic      out_free;
        dp_flags_t dp;
    } cond_flags_t;

    function automatic ctrl_t ucode_rom(input step_t s);
        ctrl_t w;
        w = '0;
        case (s)
            U_IDLE: begin
                w.cond = C_START; w.target = U_DECODE; w.hold = 1'b1;
            end
            U_DECODE: begin
                w.cond = C_DISP; w.target = U_D0; w.take = 1'b1;
                w.cur_op = CUR_IN; w.pos_op = POS_COUNT;
            end
            U_ADD: begin
                w.cond = C_FULL; w.target = U_EFULL;
            end
            U_UPTEST: begin
                w.cond = C_POS_ZERO; w.target = U_UPPLACE;
                w.rd_en = 1'b1; w.rd_sel = RD_PARENT;
            end
            U_UPCMP: begin
                w.cond = C_NOT_UP; w.target = U_UPPLACE;
            end
            U_UPMOVE: begin
                w.cond = C_ALWAYS; w.target = U_UPTEST;
                w.wr_en = 1'b1; w.wr_sel = WR_RD; w.pos_op = POS_PARENT;
            end
            U_UPPLACE: begin
                w.wr_en = 1'b1; w.wr_sel = WR_CUR; w.cnt_op = CNT_INC;
            end
            U_EADD: begin
                w.cond = C_OUT_FREE; w.target = U_IDLE; w.hold = 1'b1;
                w.emit = 1'b1; w.emit_status = ST_ADDED; w.emit_zero = 1'b1;
            end
            U_EFULL: begin
                w.cond = C_OUT_FREE; w.target = U_IDLE; w.hold = 1'b1;
                w.emit = 1'b1; w.emit_status = ST_FULL; w.emit_zero = 1'b1;
            end
            U_EEMPTY: begin
                w.cond = C_OUT_FREE; w.target = U_IDLE; w.hold = 1'b1;
                w.emit = 1'b1; w.emit_status = ST_EMPTY; w.emit_zero = 1'b1;
            end
            U_D0: begin
                w.cond = C_EMPTY; w.target = U_EEMPTY;
                w.rd_en = 1'b1; w.rd_sel = RD_ROOT;
            end
            U_D1: begin
                w.out_load = 1'b1; w.cnt_op = CNT_DEC;
            end
            U_D2: begin
                w.cond = C_EMPTY; w.target = U_EDISP;
                w.rd_en = 1'b1; w.rd_sel = RD_LAST; w.pos_op = POS_ZERO;
            end
            U_D3: begin
                w.cur_op = CUR_RD;
            end
            U_DNTEST: begin
                w.cond = C_NO_LEFT; w.target = U_DNPLACE;
                w.rd_en = 1'b1; w.rd_sel = RD_LEFT;
            end
            U_DNL: begin
                w.cond = C_NO_RIGHT; w.target = U_DNCHK;
                w.rd_en = 1'b1; w.rd_sel = RD_RIGHT; w.best_op = BEST_LEFT;
            end
            U_DNR: begin
                w.best_op = BEST_RIGHT;
            end
            U_DNCHK: begin
                w.cond = C_BEST_IS_POS; w.target = U_DNPLACE;
            end
            U_DNMOVE: begin
                w.cond = C_ALWAYS; w.target = U_DNTEST;
                w.wr_en = 1'b1; w.wr_sel = WR_BEST; w.pos_op = POS_BEST;
            end
            U_DNPLACE: begin
                w.wr_en = 1'b1; w.wr_sel = WR_CUR;
            end
            U_EDISP: begin
                w.cond = C_OUT_FREE; w.target = U_IDLE; w.hold = 1'b1;
                w.emit = 1'b1; w.emit_status = ST_DISPATCHED;
            end
            default: begin
                w.cond = C_ALWAYS; w.target = U_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/sph_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module sph_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/sph_seq.sv =====
// microcode sequencer: step counter, control rom and conditional jumps
// depends on sph_pkg
`default_nettype none

module sph_seq (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire sph_pkg::cond_flags_t flags,
    output sph_pkg::ctrl_t           ctrl
);

    import sph_pkg::*;

    step_t step_reg;
    step_t step_next;
    logic  cond_hit;

    assign ctrl = ucode_rom(step_reg);

    always_comb begin
        case (ctrl.cond)
            C_NEVER:       cond_hit = 1'b0;
            C_ALWAYS:      cond_hit = 1'b1;
            C_START:       cond_hit = flags.start;
            C_DISP:        cond_hit = flags.disp;
            C_FULL:        cond_hit = flags.dp.full;
            C_POS_ZERO:    cond_hit = flags.dp.pos_zero;
            C_NOT_UP:      cond_hit = flags.dp.not_up;
            C_EMPTY:       cond_hit = flags.dp.empty;
            C_NO_LEFT:     cond_hit = flags.dp.no_left;
            C_NO_RIGHT:    cond_hit = flags.dp.no_right;
            C_BEST_IS_POS: cond_hit = flags.dp.best_is_pos;
            C_OUT_FREE:    cond_hit = flags.out_free;
            default:       cond_hit = 1'b0;
        endcase
    end

    always_comb begin
        if (cond_hit) begin
            step_next = ctrl.target;
        end else if (ctrl.hold) begin
            step_next = step_reg;
        end else begin
            step_next = step_reg + step_t'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= U_IDLE;
        end else begin
            step_reg <= step_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/sph_dpath.sv =====
// heap datapath: entry count, position and entry registers, compare, heap ram
// depends on sph_pkg and sph_ram
`default_nettype none

module sph_dpath (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire sph_pkg::ctrl_t  ctrl,
    input  wire sph_pkg::entry_t in_ent,
    output sph_pkg::dp_flags_t   flags,
    output sph_pkg::entry_t      out_ent
);

    import sph_pkg::*;

    function automatic logic ranks_above(input entry_t a, input entry_t b);
        if (a.sev != b.sev) begin
            return a.sev > b.sev;
        end
        return a.ts < b.ts;
    endfunction

    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [AW-1:0] pos_reg;
    logic [AW-1:0] pos_next;
    logic [AW-1:0] bpos_reg;
    logic [AW-1:0] bpos_next;
    entry_t        cur_reg;
    entry_t        cur_next;
    entry_t        best_reg;
    entry_t        best_next;
    entry_t        out_reg;

    logic [ENTRY_W-1:0] ram_rdata;
    logic [ENTRY_W-1:0] ram_wdata;
    logic [AW-1:0]      ram_raddr;
    entry_t             rd_ent;

    logic [AW-1:0] parent_addr;
    logic [LW-1:0] left_idx;
    logic [LW-1:0] right_idx;
    logic [LW-1:0] count_ext;

    assign rd_ent      = entry_t'(ram_rdata);
    assign parent_addr = (pos_reg - AW'(1)) >> 1;
    assign left_idx    = {1'b0, pos_reg, 1'b1};
    assign right_idx   = left_idx + LW'(1);
    assign count_ext   = LW'(count_reg);

    always_comb begin
        case (ctrl.rd_sel)
            RD_PARENT: ram_raddr = parent_addr;
            RD_ROOT:   ram_raddr = '0;
            RD_LAST:   ram_raddr = count_reg[AW-1:0];
            RD_LEFT:   ram_raddr = left_idx[AW-1:0];
            RD_RIGHT:  ram_raddr = right_idx[AW-1:0];
            default:   ram_raddr = '0;
        endcase
    end

    always_comb begin
        case (ctrl.wr_sel)
            WR_RD:   ram_wdata = rd_ent;
            WR_CUR:  ram_wdata = cur_reg;
            WR_BEST: ram_wdata = best_reg;
            default: ram_wdata = cur_reg;
        endcase
    end

    sph_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(CAPACITY)
    ) u_heap_ram (
        .aclk (aclk),
        .we   (ctrl.wr_en),
        .waddr(pos_reg),
        .wdata(ram_wdata),
        .re   (ctrl.rd_en),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    always_comb begin
        case (ctrl.cnt_op)
            CNT_INC: count_next = count_reg + CW'(1);
            CNT_DEC: count_next = count_reg - CW'(1);
            default: count_next = count_reg;
        endcase

        case (ctrl.pos_op)
            POS_COUNT:  pos_next = count_reg[AW-1:0];
            POS_ZERO:   pos_next = '0;
            POS_PARENT: pos_next = parent_addr;
            POS_BEST:   pos_next = bpos_reg;
            default:    pos_next = pos_reg;
        endcase

        case (ctrl.cur_op)
            CUR_IN:  cur_next = in_ent;
            CUR_RD:  cur_next = rd_ent;
            default: cur_next = cur_reg;
        endcase

        best_next = best_reg;
        bpos_next = bpos_reg;
        case (ctrl.best_op)
            BEST_LEFT: begin
                if (ranks_above(rd_ent, cur_reg)) begin
                    best_next = rd_ent;
                    bpos_next = left_idx[AW-1:0];
                end else begin
                    best_next = cur_reg;
                    bpos_next = pos_reg;
                end
            end
            BEST_RIGHT: begin
                if (ranks_above(rd_ent, best_reg)) begin
                    best_next = rd_ent;
                    bpos_next = right_idx[AW-1:0];
                end
            end
            default: begin
                best_next = best_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        pos_reg  <= pos_next;
        bpos_reg <= bpos_next;
        cur_reg  <= cur_next;
        best_reg <= best_next;
        if (ctrl.out_load) begin
            out_reg <= rd_ent;
        end
    end

    assign out_ent           = out_reg;
    assign flags.full        = (count_reg == CW'(CAPACITY));
    assign flags.empty       = (count_reg == '0);
    assign flags.pos_zero    = (pos_reg == '0);
    assign flags.not_up      = !ranks_above(cur_reg, rd_ent);
    assign flags.no_left     = (left_idx >= count_ext);
    assign flags.no_right    = (right_idx >= count_ext);
    assign flags.best_is_pos = (bpos_reg == pos_reg);

endmodule

`default_nettype wire

// ===== rtl/severity_priority_heap_top.sv =====
// top level of the severity priority heap: stream ports, input and output registers
// depends on sph_pkg, sph_seq and sph_dpath
`default_nettype none

// Binary max-heap priority queue of 128 entries, ranked by higher severity first and
// earlier timestamp on ties. Each input transaction (tuser 0 = add, 1 = dispatch)
// yields exactly one result transaction. One item is processed at a time; a second
// item is buffered while the first is at work. An add sifts the new entry up level by
// level and a dispatch sifts the last entry down from the root, in microcode steps
// built around the single read port of the heap ram, whose read data is registered.
// No clearing pass is needed after reset.
module severity_priority_heap_top (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // severity[7:0], timestamp[39:8], payload_tag[55:40]
    input  wire logic [sph_pkg::S_TDATA_W-1:0]   s_tdata,
    // mode
    input  wire logic                            s_tuser,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // out_severity[7:0], out_timestamp[39:8], out_tag[55:40], is_empty[56]
    output logic      [sph_pkg::M_TDATA_W-1:0]   m_tdata,
    // status
    output logic      [1:0]                      m_tuser
);

    import sph_pkg::*;

    logic        in_full_reg;
    logic        in_full_next;
    logic        in_mode_reg;
    entry_t      in_ent_reg;

    logic        m_tvalid_reg;
    logic        m_tvalid_next;
    status_t     out_status_reg;
    entry_t      out_ent_reg;
    logic        out_empty_reg;

    ctrl_t       ctrl;
    dp_flags_t   dp_flags;
    cond_flags_t cond_flags;
    entry_t      dp_out_ent;
    logic        out_free;
    logic        emit_fire;

    assign s_tready  = !in_full_reg;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign emit_fire = ctrl.emit && out_free;

    assign cond_flags.start    = in_full_reg;
    assign cond_flags.disp     = in_mode_reg;
    assign cond_flags.out_free = out_free;
    assign cond_flags.dp       = dp_flags;

    sph_seq u_seq (
        .aclk   (aclk),
        .aresetn(aresetn),
        .flags  (cond_flags),
        .ctrl   (ctrl)
    );

    sph_dpath u_dpath (
        .aclk   (aclk),
        .aresetn(aresetn),
        .ctrl   (ctrl),
        .in_ent (in_ent_reg),
        .flags  (dp_flags),
        .out_ent(dp_out_ent)
    );

    always_comb begin
        in_full_next = in_full_reg;
        if (ctrl.take) begin
            in_full_next = 1'b0;
        end
        if (s_tvalid && s_tready) begin
            in_full_next = 1'b1;
        end

        m_tvalid_next = m_tvalid_reg;
        if (emit_fire) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_full_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            in_full_reg  <= in_full_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_mode_reg <= s_tuser;
            in_ent_reg  <= entry_t'(s_tdata[ENTRY_W-1:0]);
        end
        if (emit_fire) begin
            out_status_reg <= ctrl.emit_status;
            out_ent_reg    <= ctrl.emit_zero ? entry_t'('0) : dp_out_ent;
            out_empty_reg  <= dp_flags.empty;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {(M_TDATA_W - ENTRY_W - 1)'(0), out_empty_reg, out_ent_reg};

endmodule

`default_nettype wire

// ===== rtl/sph_checker.sv =====
// port-level checker for the severity priority heap, bound to the top level
// depends on sph_pkg and severity_priority_heap_top
`default_nettype none

module sph_checker (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          s_tready,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [sph_pkg::M_TDATA_W-1:0] m_tdata,
    input wire logic [1:0]                    m_tuser
);

    import sph_pkg::*;

    // stalled result transaction holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // only a dispatch carries an entry
    a_zero_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != ST_DISPATCHED) |-> (m_tdata[ENTRY_W-1:0] == '0))
        else $error("non-dispatch result carries entry fields");

    a_empty_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == ST_EMPTY) |-> m_tdata[ENTRY_W])
        else $error("empty status without is_empty");

    a_full_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == ST_FULL) |-> !m_tdata[ENTRY_W])
        else $error("full status with is_empty");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("ports not idle after reset");

endmodule

bind severity_priority_heap_top sph_checker u_sph_checker (.*);

`default_nettype wire

// ===== test/sph_tb_pkg.sv =====
`timescale 1ns / 1ps
// severity priority heap testbench: codes shared by the checker and the stimulus
// no dependencies

package sph_tb_pkg;

    typedef enum logic {
        MODE_ADD      = 1'b0,
        MODE_DISPATCH = 1'b1
    } mode_t;

endpackage

// ===== test/severity_priority_heap_checker.sv =====
`timescale 1ns / 1ps
// severity priority heap checker: watches both stream channels, keeps its own heap
// and compares every result; depends on sph_pkg and sph_tb_pkg
module severity_priority_heap_checker (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    input  wire logic                          s_tready,
    input  wire logic [sph_pkg::S_TDATA_W-1:0] s_tdata,
    input  wire logic                          s_tuser,
    input  wire logic                          m_tvalid,
    input  wire logic                          m_tready,
    input  wire logic [sph_pkg::M_TDATA_W-1:0] m_tdata,
    input  wire logic [1:0]                    m_tuser,
    output int                                 mismatch_count,
    output int                                 pending
);
    import sph_pkg::*;
    import sph_tb_pkg::*;

    typedef struct {
        status_t status;
        entry_t  ent;
        logic    empty;
    } outcome_t;

    entry_t   heap_mem [CAPACITY];
    int       held = 0;
    int       fails = 0;
    outcome_t outcome_q [$];

    assign mismatch_count = fails;
    assign pending = outcome_q.size();

    function automatic logic outranks(entry_t a, entry_t b);
        if (a.sev != b.sev) return a.sev > b.sev;
        return a.ts < b.ts;
    endfunction

    task automatic swap_slots(int i, int j);
        entry_t t;
        t = heap_mem[i];
        heap_mem[i] = heap_mem[j];
        heap_mem[j] = t;
    endtask

    task automatic heap_step(input mode_t mode, input entry_t item, output outcome_t res);
        int pos, up, lc, rc, best;
        res.status = ST_ADDED;
        res.ent = '0;
        if (mode == MODE_ADD) begin
            if (held >= CAPACITY) begin
                res.status = ST_FULL;
            end else begin
                pos = held;
                heap_mem[pos] = item;
                while (pos > 0) begin
                    up = (pos - 1) / 2;
                    if (!outranks(heap_mem[pos], heap_mem[up])) break;
                    swap_slots(pos, up);
                    pos = up;
                end
                held++;
            end
        end else if (held == 0) begin
            res.status = ST_EMPTY;
        end else begin
            res.status = ST_DISPATCHED;
            res.ent = heap_mem[0];
            held--;
            heap_mem[0] = heap_mem[held];
            pos = 0;
            while (pos < held) begin
                lc = 2 * pos + 1;
                rc = 2 * pos + 2;
                best = pos;
                if (lc < held && outranks(heap_mem[lc], heap_mem[best])) best = lc;
                if (rc < held && outranks(heap_mem[rc], heap_mem[best])) best = rc;
                if (best == pos) break;
                swap_slots(pos, best);
                pos = best;
            end
        end
        res.empty = (held == 0);
    endtask

    task automatic note_mismatch(string what, logic [63:0] want, logic [63:0] got);
        fails++;
        if (fails <= 10)
            $display("%0t ns: mismatch on %s, expected %h, got %h", $time, what, want, got);
    endtask

    task automatic check_result();
        outcome_t want;
        if (outcome_q.size() == 0) begin
            note_mismatch("unexpected result transaction", '0, m_tdata);
            return;
        end
        want = outcome_q.pop_front();
        if (m_tuser != want.status)
            note_mismatch("status", 64'(want.status), 64'(m_tuser));
        if (m_tdata[7:0] != want.ent.sev)
            note_mismatch("out_severity", 64'(want.ent.sev), 64'(m_tdata[7:0]));
        if (m_tdata[39:8] != want.ent.ts)
            note_mismatch("out_timestamp", 64'(want.ent.ts), 64'(m_tdata[39:8]));
        if (m_tdata[55:40] != want.ent.tag)
            note_mismatch("out_tag", 64'(want.ent.tag), 64'(m_tdata[55:40]));
        if (m_tdata[56] !== want.empty)
            note_mismatch("is_empty", 64'(want.empty), 64'(m_tdata[56]));
        if (m_tdata[63:57] !== '0)
            note_mismatch("tdata padding", '0, 64'(m_tdata[63:57]));
    endtask

    always @(posedge aclk) begin
        outcome_t res;
        if (!aresetn) begin
            held = 0;
            outcome_q.delete();
        end else begin
            if (s_tvalid && s_tready) begin
                heap_step(mode_t'(s_tuser), entry_t'(s_tdata), res);
                outcome_q.push_back(res);
            end
            if (m_tvalid && m_tready) check_result();
        end
    end

endmodule

// ===== test/severity_priority_heap_top_tb.sv =====
`timescale 1ns / 1ps
// severity priority heap testbench top: clock, reset, stimulus and verdict
// depends on sph_pkg, sph_tb_pkg, severity_priority_heap_checker and the rtl
module severity_priority_heap_top_tb;
    import sph_pkg::*;
    import sph_tb_pkg::*;

    localparam int HOLD_LEN = 300;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tuser = 1'b0;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic                 m_tready = 1'b0;
    logic                 s_tready;
    logic                 m_tvalid;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [1:0]           m_tuser;
    int                   mismatch_count;
    int                   pending;

    bit tx_bursty = 1'b1;
    bit rx_bursty = 1'b1;
    bit hold_req = 1'b0;
    int items_sent = 0;

    always #2 aclk = ~aclk;

    severity_priority_heap_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    severity_priority_heap_checker checker_i (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .mismatch_count (mismatch_count),
        .pending        (pending)
    );

    function automatic entry_t rand_entry();
        entry_t e;
        case ($urandom_range(0, 2))
            0: e.sev = 8'($urandom_range(0, 255));
            1: e.sev = 8'($urandom_range(0, 3));
            default: e.sev = $urandom_range(0, 1) ? 8'hff : 8'h00;
        endcase
        e.ts = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3) : $urandom();
        e.tag = 16'($urandom_range(0, 65535));
        return e;
    endfunction

    function automatic entry_t make_entry(logic [7:0] sev, logic [31:0] ts, logic [15:0] tag);
        entry_t e;
        e.sev = sev;
        e.ts = ts;
        e.tag = tag;
        return e;
    endfunction

    task automatic offer(mode_t mode, entry_t e);
        if (tx_bursty && $urandom_range(0, 5) == 0) begin
            @(negedge aclk);
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 16) - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid = 1'b1;
        s_tuser = mode;
        s_tdata = e;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (pending != 0) @(negedge aclk);
    endtask

    // result side: random stall bursts, plus one long hold-off on request
    initial begin
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_tready = 1'b0;
                repeat (HOLD_LEN - 1) @(negedge aclk);
            end else if (rx_bursty && $urandom_range(0, 7) == 0) begin
                m_tready = 1'b0;
                repeat ($urandom_range(1, 16) - 1) @(negedge aclk);
            end else begin
                m_tready = 1'b1;
            end
        end
    end

    initial begin
        int seg_len;
        int add_pct;
        repeat (7) @(negedge aclk);
        aresetn = 1'b1;

        // empty dispatch, field extremes, severity and timestamp ties
        offer(MODE_DISPATCH, make_entry(8'hff, 32'hffffffff, 16'hffff));
        offer(MODE_ADD, make_entry(8'h00, 32'h00000000, 16'h0000));
        offer(MODE_ADD, make_entry(8'hff, 32'hffffffff, 16'hffff));
        offer(MODE_ADD, make_entry(8'hff, 32'h00000000, 16'h1234));
        offer(MODE_ADD, make_entry(8'hff, 32'h00000000, 16'habcd));
        offer(MODE_ADD, make_entry(8'h80, 32'h80000000, 16'h8000));
        offer(MODE_ADD, make_entry(8'h7f, 32'h7fffffff, 16'h7fff));
        offer(MODE_ADD, make_entry(8'h01, 32'h00000001, 16'h0001));
        repeat (8) offer(MODE_DISPATCH, make_entry(8'h00, 32'h0, 16'h0));
        wait_drained();

        // fill past capacity while results are held back, then dispatch past empty
        hold_req = 1'b1;
        repeat (CAPACITY + 12) offer(MODE_ADD, rand_entry());
        repeat (CAPACITY + 6) offer(MODE_DISPATCH, rand_entry());
        wait_drained();

        while (items_sent < 1700) begin
            seg_len = $urandom_range(20, 120);
            case ($urandom_range(0, 2))
                0: add_pct = 15;
                1: add_pct = 50;
                default: add_pct = 80;
            endcase
            tx_bursty = ($urandom_range(0, 3) != 0);
            rx_bursty = ($urandom_range(0, 3) != 0);
            repeat (seg_len)
                offer(($urandom_range(1, 100) <= add_pct) ? MODE_ADD : MODE_DISPATCH,
                      rand_entry());
        end

        tx_bursty = 1'b0;
        rx_bursty = 1'b0;
        repeat (200)
            offer($urandom_range(0, 1) ? MODE_ADD : MODE_DISPATCH, rand_entry());

        wait_drained();
        repeat (100) @(negedge aclk);
        if (mismatch_count == 0 && pending == 0)
            $display("severity_priority_heap_top_tb: clean");
        else
            $display("severity_priority_heap_top_tb: errors");
        $finish;
    end

    initial begin
        #3_000_000;
        $display("severity_priority_heap_top_tb: errors");
        $finish;
    end

endmodule
